### hdl/ordered_list_deque_unit_macros.svh
// Assertion macros shared by the ordered list deque RTL.
// Depends on nothing; the including module must provide clk and rst.
`ifndef ORDERED_LIST_DEQUE_UNIT_MACROS_SVH
`define ORDERED_LIST_DEQUE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define OLQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define OLQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/olq_pkg.sv
// Shared types and codes for the ordered list deque.
// Used by olq_cell and ordered_list_deque_unit; depends on nothing.
`timescale 1ns / 1ps

package olq_pkg;

  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_REM_FRONT = 3'd2,
    OP_REM_BACK  = 3'd3,
    OP_REM_VALUE = 3'd4
  } op_t;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [2:0]               operation;
    logic signed [DATA_W-1:0] value;
  } olq_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] count;
  } olq_rsp_t;

  // Broadcast controls from the sequencer to every cell.
  typedef struct packed {
    logic capture;    // register the compare against the incoming value
    logic commit;     // apply the update selected below
    logic ins_front;
    logic ins_back;
    logic rem_front;
    logic rem_value;
  } olq_cell_ctrl_t;

endpackage

### hdl/olq_cell.sv
// One list position: holds an entry and its registered compare result.
// Depends on olq_pkg; neighbors are wired by ordered_list_deque_unit.
`timescale 1ns / 1ps

module olq_cell (
  input  logic                   clk,
  input  olq_pkg::olq_cell_ctrl_t ctrl,
  input  logic                   occupied,
  input  logic                   tail,
  input  logic [olq_pkg::DATA_W-1:0] cmp_value,
  input  logic [olq_pkg::DATA_W-1:0] ins_value,
  input  logic [olq_pkg::DATA_W-1:0] left_data,
  input  logic [olq_pkg::DATA_W-1:0] right_data,
  input  logic                   found_in,
  output logic                   found_out,
  output logic [olq_pkg::DATA_W-1:0] data
);
  import olq_pkg::*;

  logic match;

  // A cell at or behind the first match pulls its right neighbor forward.
  assign found_out = found_in | match;

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      match <= occupied && (data == cmp_value);
    end
    if (ctrl.commit) begin
      priority if (ctrl.ins_front) begin
        data <= left_data;
      end else if (ctrl.ins_back && tail) begin
        data <= ins_value;
      end else if (ctrl.rem_front) begin
        data <= right_data;
      end else if (ctrl.rem_value && found_out) begin
        data <= right_data;
      end
    end
  end

endmodule

### hdl/ordered_list_deque_unit.sv
// Top level of the ordered list deque: sequencer, entry count and cell row.
// Depends on olq_pkg, olq_cell and ordered_list_deque_unit_macros.svh.
//
//  channel | direction | payload    | handshake
//  req     | in        | olq_req_t  | req_valid / req_ready
//  rsp     | out       | olq_rsp_t  | rsp_valid / rsp_ready
//
// The accept edge registers every cell's compare, and the commit edge shifts
// the cell row and loads the response register.
// The found flag ripples through the cells in the execute state.
// Reset clears the entry count, so the list is empty at once; no sweep needed.
// A response not yet taken holds the next request in its execute cycle.
`timescale 1ns / 1ps

`include "ordered_list_deque_unit_macros.svh"

module ordered_list_deque_unit #(
  parameter int CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  olq_pkg::olq_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output olq_pkg::olq_rsp_t rsp
);
  import olq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int WIDE_W = CNT_W + 5;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t                 state;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;
  logic [WIDE_W-1:0]      count_wide;
  logic [2:0]             op_q;
  logic [DATA_W-1:0]      val_q;
  logic [1:0]             status_next;
  logic                   full;
  logic                   empty;
  logic                   found;
  olq_cell_ctrl_t         ctrl;
  logic [DATA_W-1:0]      cell_data [CAPACITY];
  logic [CAPACITY:0]      found_chain;
  logic [4:0]             count_now;
  logic                   ins_full;
  logic                   rem_hit;

  assign req_ready = (state == S_IDLE);
  assign full      = (count == CNT_W'(CAPACITY));
  assign empty     = (count == '0);
  assign found     = found_chain[CAPACITY];
  assign found_chain[0] = 1'b0;

  always_comb begin
    status_next    = ST_DONE;
    count_next     = count;
    ctrl           = '0;
    ctrl.capture   = req_valid && req_ready;
    ctrl.commit    = (state == S_EXEC) && (!rsp_valid || rsp_ready);
    unique case (op_q)
      OP_INS_FRONT, OP_INS_BACK: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          count_next     = count + 1'b1;
          ctrl.ins_front = (op_q == OP_INS_FRONT);
          ctrl.ins_back  = (op_q == OP_INS_BACK);
        end
      end
      OP_REM_FRONT, OP_REM_BACK: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          count_next     = count - 1'b1;
          ctrl.rem_front = (op_q == OP_REM_FRONT);
        end
      end
      OP_REM_VALUE: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else if (found) begin
          count_next     = count - 1'b1;
          ctrl.rem_value = 1'b1;
        end else begin
          status_next = ST_NOTFOUND;
        end
      end
      default: begin
        status_next = ST_DONE;
      end
    endcase
  end

  assign count_wide = WIDE_W'(count_next);
  assign count_now  = 5'(count);
  assign ins_full   = ctrl.commit && full &&
                      ((op_q == OP_INS_FRONT) || (op_q == OP_INS_BACK));
  assign rem_hit    = ctrl.commit && ctrl.rem_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            op_q  <= req.operation;
            val_q <= req.value;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (ctrl.commit) begin
            count      <= count_next;
            rsp.status <= status_next;
            rsp.count  <= count_wide[4:0];
            rsp_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_data;
    logic [DATA_W-1:0] right_data;

    if (i == 0) begin : g_head
      assign left_data = val_q;
    end else begin : g_mid
      assign left_data = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_data = cell_data[i];
    end else begin : g_inner
      assign right_data = cell_data[i+1];
    end

    olq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (CNT_W'(i) < count),
      .tail       (CNT_W'(i) == count),
      .cmp_value  (req.value),
      .ins_value  (val_q),
      .left_data  (left_data),
      .right_data (right_data),
      .found_in   (found_chain[i]),
      .found_out  (found_chain[i+1]),
      .data       (cell_data[i])
    );
  end

  `OLQ_ASSERT_IMP(a_count_bound, 1'b1, count <= CNT_W'(CAPACITY), "entry count above capacity")
  `OLQ_ASSERT_NXT(a_accept_exec, req_valid && req_ready, state == S_EXEC, "request not executed")
  `OLQ_ASSERT_NXT(a_rsp_count, ctrl.commit, rsp_valid && rsp.count == count_now, "bad rsp count")
  `OLQ_ASSERT_NXT(a_full_hold, ins_full, count == $past(count), "insert changed a full list")
  `OLQ_ASSERT_NXT(a_rem_dec, rem_hit, count == $past(count) - 1'b1, "value removal miscounted")

endmodule

### bench/tb.sv
// Self-checking bench for ordered_list_deque_unit: directed list edge cases, then random traffic.
// Depends on olq_pkg and the ordered_list_deque_unit RTL; a queue mirror predicts every response.
`timescale 1ns / 1ps

module tb;

  import olq_pkg::*;

  localparam int CAPACITY = 16;
  localparam logic [2:0] OP_NOP_FIRST = 3'd5;
  localparam logic [2:0] OP_NOP_LAST  = 3'd7;
  localparam int MAX_REPORTS = 25;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_ready;
  olq_req_t req = '0;
  logic     rsp_valid;
  logic     rsp_ready = 1'b0;
  olq_rsp_t rsp;

  // Mirror of the list contents, front at index 0.
  logic signed [DATA_W-1:0] mirror_list[$];
  olq_rsp_t awaited_rsp[$];

  bit idle_on = 1'b1;
  int stall_left = 0;
  int fail_count = 0;
  int sent_count = 0;
  int checked_count = 0;
  int full_hits = 0;
  int value_hits = 0;
  int miss_hits = 0;

  ordered_list_deque_unit #(.CAPACITY(CAPACITY)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Applies one operation to the mirror and returns the response it should produce.
  function automatic olq_rsp_t list_apply(logic [2:0] op, logic signed [DATA_W-1:0] val);
    olq_rsp_t r;
    int idx;
    r.status = ST_DONE;
    idx = -1;
    case (op)
      OP_INS_FRONT: begin
        if (mirror_list.size() >= CAPACITY) begin
          r.status = ST_FULL;
          full_hits++;
        end else begin
          mirror_list.push_front(val);
        end
      end
      OP_INS_BACK: begin
        if (mirror_list.size() >= CAPACITY) begin
          r.status = ST_FULL;
          full_hits++;
        end else begin
          mirror_list.push_back(val);
        end
      end
      OP_REM_FRONT: begin
        if (mirror_list.size() == 0) r.status = ST_EMPTY;
        else void'(mirror_list.pop_front());
      end
      OP_REM_BACK: begin
        if (mirror_list.size() == 0) r.status = ST_EMPTY;
        else void'(mirror_list.pop_back());
      end
      OP_REM_VALUE: begin
        if (mirror_list.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (int i = 0; i < mirror_list.size(); i++) begin
            if (idx < 0 && mirror_list[i] === val) idx = i;
          end
          if (idx < 0) begin
            r.status = ST_NOTFOUND;
            miss_hits++;
          end else begin
            mirror_list.delete(idx);
            value_hits++;
          end
        end
      end
      default: ;
    endcase
    r.count = 5'(mirror_list.size());
    return r;
  endfunction

  // Mostly short gaps, now and then a long one; none while idling is off.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Response side: random back-pressure and the in-order compare.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        checked_count++;
        if (awaited_rsp.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) $error("response arrived with none outstanding");
        end else begin
          olq_rsp_t want;
          want = awaited_rsp.pop_front();
          if (rsp.status !== want.status) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $error("status: expected %0d, actual %0d", want.status, rsp.status);
          end
          if (rsp.count !== want.count) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $error("count: expected %0d, actual %0d", want.count, rsp.count);
          end
        end
      end
      if (stall_left > 0) begin
        rsp_ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 99) < 30) begin
        rsp_ready <= 1'b0;
        stall_left <= pick_gap();
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // Sends one request, holding it until accepted, then records its prediction.
  task automatic send_request(input logic [2:0] op, input logic signed [DATA_W-1:0] val);
    int gap;
    olq_req_t item;
    gap = pick_gap();
    item.operation = op;
    item.value = val;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (!req_ready);
    awaited_rsp.push_back(list_apply(op, val));
    sent_count++;
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (awaited_rsp.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] edge_value(int i);
    case (i % 8)
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return 32'sh0000_0000;
      3: return -32'sd1;
      4: return 32'sh0000_0001;
      5: return 32'sh5555_5555;
      6: return 32'shAAAA_AAAA;
      default: return -32'sd1;
    endcase
  endfunction

  task automatic test_empty_list();
    send_request(OP_REM_FRONT, 32'sh0);
    send_request(OP_REM_BACK, 32'sh7FFF_FFFF);
    send_request(OP_REM_VALUE, 32'sh8000_0000);
    send_request(OP_NOP_FIRST, -32'sd1);
    send_request(OP_NOP_LAST, 32'sh0);
  endtask

  task automatic test_fill_overflow();
    for (int i = 0; i < CAPACITY; i++) begin
      send_request((i % 2 == 0) ? OP_INS_FRONT : OP_INS_BACK, edge_value(i));
    end
    send_request(OP_INS_FRONT, 32'sh1234_5678);
    send_request(OP_INS_BACK, 32'sh8000_0000);
    send_request(OP_NOP_FIRST + 3'd1, 32'sh7FFF_FFFF);
  endtask

  task automatic test_value_removal();
    // The list holds several copies of -1; only the one nearest the front goes.
    send_request(OP_REM_VALUE, 32'sh1234_5678);
    send_request(OP_REM_VALUE, -32'sd1);
    send_request(OP_REM_VALUE, 32'sh7FFF_FFFF);
    send_request(OP_REM_FRONT, 32'sh0);
    send_request(OP_REM_BACK, 32'sh0);
  endtask

  task automatic test_random_ops(input int n_items);
    int phase;
    int r;
    logic [2:0] op;
    logic signed [DATA_W-1:0] val;
    phase = 0;
    for (int k = 0; k < n_items; k++) begin
      // Every 50 requests switch between filling, draining and a balanced mix.
      if (k % 50 == 0) begin
        phase = $urandom_range(0, 2);
        idle_on = ($urandom_range(0, 3) != 0);
      end
      r = $urandom_range(0, 99);
      case (phase)
        0: op = (r < 35) ? OP_INS_FRONT : (r < 70) ? OP_INS_BACK : (r < 78) ? OP_REM_FRONT :
                (r < 84) ? OP_REM_BACK : (r < 96) ? OP_REM_VALUE : OP_NOP_FIRST;
        1: op = (r < 12) ? OP_INS_FRONT : (r < 24) ? OP_INS_BACK : (r < 44) ? OP_REM_FRONT :
                (r < 64) ? OP_REM_BACK : (r < 95) ? OP_REM_VALUE : OP_NOP_FIRST;
        default: op = (r < 22) ? OP_INS_FRONT : (r < 44) ? OP_INS_BACK : (r < 58) ? OP_REM_FRONT :
                      (r < 72) ? OP_REM_BACK : (r < 96) ? OP_REM_VALUE : OP_NOP_FIRST;
      endcase
      if (op == OP_NOP_FIRST) op = 3'($urandom_range(OP_NOP_FIRST, OP_NOP_LAST));
      r = $urandom_range(0, 99);
      if (r < 40) val = $signed(32'($urandom_range(0, 7))) - 32'sd4;
      else if (r < 50) val = (r < 45) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      else val = $signed($urandom());
      // Most value removals aim at an entry that is present.
      if (op == OP_REM_VALUE && mirror_list.size() != 0 && $urandom_range(0, 99) < 60)
        val = mirror_list[$urandom_range(0, mirror_list.size() - 1)];
      send_request(op, val);
    end
    idle_on = 1'b1;
  endtask

  initial begin
    mirror_list.delete();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_empty_list();
    test_fill_overflow();
    test_value_removal();
    test_random_ops(550);
    // Let every outstanding response come back before the second random stretch.
    wait_drained();
    test_random_ops(550);
    wait_drained();
    repeat (10) @(posedge clk);
    $display("Sent %0d requests and checked %0d responses.", sent_count, checked_count);
    $display("Full rejections %0d, value removals %0d, values not found %0d.",
             full_hits, value_hits, miss_hits);
    if (fail_count == 0 && awaited_rsp.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
